/* sv/assert_macros.svh */
// ---------------------------------------------------------------------------
// assert_macros.svh
// clocked assertion helpers for checker modules
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every rising edge, off while reset is low
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// implication checked at every rising edge, off while reset is low
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    `ASSERT_CLK(label, clk, rst_n, (ante) |-> (cons), msg)

`endif

/* sv/hexd_pkg.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// hexd_pkg
// types, codes and helpers of the hex escape decoder
// ---------------------------------------------------------------------------
package hexd_pkg;

    localparam int CHAR_W  = 8;
    localparam int COUNT_W = 16;
    localparam int CFG_W   = 16;

    localparam logic [CHAR_W-1:0]  CH_NUL    = 8'h00;
    localparam logic [CHAR_W-1:0]  CH_BSLASH = 8'h5C;
    localparam logic [CHAR_W-1:0]  CH_X      = 8'h78;
    localparam logic [CHAR_W-1:0]  CH_ZERO   = 8'h30;
    localparam logic [CHAR_W-1:0]  CH_UP_A   = 8'h41;
    localparam logic [CHAR_W-1:0]  CH_LO_A   = 8'h61;
    localparam logic [CHAR_W-1:0]  DIGIT_TEN = 8'd10;
    localparam logic [COUNT_W-1:0] COUNT_MAX = 16'hFFFF;

    typedef enum logic [0:0] {
        CFG_OUT_CAPACITY = 1'b0,
        CFG_COUNT_ONLY   = 1'b1
    } cfg_idx_t;

    typedef enum logic [1:0] {
        ST_DATA  = 2'd0,
        ST_DONE  = 2'd1,
        ST_ERROR = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        PH_TEXT   = 2'd0,
        PH_BSLASH = 2'd1,
        PH_X      = 2'd2,
        PH_HIGH   = 2'd3
    } phase_t;

    typedef struct packed {
        logic [CHAR_W-1:0]  out_byte;
        status_t            status;
        logic [COUNT_W-1:0] out_count;
        logic               last;
    } result_t;

    typedef struct packed {
        logic       ok;
        logic [3:0] val;
    } hex_t;

    function automatic hex_t hex_decode(input logic [CHAR_W-1:0] ch);
        hex_t h;
        h.ok  = 1'b1;
        h.val = '0;
        if (ch >= CH_ZERO && ch <= CH_ZERO + 8'd9) begin
            h.val = 4'(ch - CH_ZERO);
        end else if (ch >= CH_UP_A && ch <= CH_UP_A + 8'd5) begin
            h.val = 4'(ch - CH_UP_A + DIGIT_TEN);
        end else if (ch >= CH_LO_A && ch <= CH_LO_A + 8'd5) begin
            h.val = 4'(ch - CH_LO_A + DIGIT_TEN);
        end else begin
            h.ok = 1'b0;
        end
        return h;
    endfunction

endpackage

/* sv/hexd_in_stage.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// hexd_in_stage
// input register holding one character until the decoder takes it
// ---------------------------------------------------------------------------
module hexd_in_stage (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [hexd_pkg::CHAR_W-1:0] s_tdata,
    input  logic                       consume,
    output logic                       in_valid,
    output logic [hexd_pkg::CHAR_W-1:0] in_char
);
    import hexd_pkg::*;

    logic              valid_reg;
    logic              valid_next;
    logic [CHAR_W-1:0] char_reg;
    logic              take;

    assign s_tready   = !valid_reg || consume;
    assign take       = s_tvalid && s_tready;
    assign valid_next = take ? 1'b1 : (consume ? 1'b0 : valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            char_reg <= s_tdata;
        end
    end

    assign in_valid = valid_reg;
    assign in_char  = char_reg;

endmodule

/* sv/hexd_core.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// hexd_core
// escape decoder state, config registers and per-character decode
// ---------------------------------------------------------------------------
module hexd_core (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_we,
    input  hexd_pkg::cfg_idx_t          cfg_index,
    input  logic [hexd_pkg::CFG_W-1:0]  cfg_data,
    input  logic                        consume,
    input  logic [hexd_pkg::CHAR_W-1:0] in_char,
    output logic                        produce,
    output hexd_pkg::result_t           result
);
    import hexd_pkg::*;

    logic [COUNT_W-1:0] capacity_reg;
    logic               count_only_reg;
    phase_t             phase_reg, phase_next;
    logic [3:0]         nibble_reg, nibble_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic               discard_reg, discard_next;

    hex_t               hex;
    logic               is_nul;
    logic               full;
    logic               add;
    logic [CHAR_W-1:0]  add_val;
    logic               fail;
    logic [COUNT_W-1:0] count_sat;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            capacity_reg   <= COUNT_MAX;
            count_only_reg <= 1'b0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_OUT_CAPACITY: capacity_reg   <= cfg_data;
                CFG_COUNT_ONLY:   count_only_reg <= cfg_data[0];
                default:          ;
            endcase
        end
    end

    assign hex       = hex_decode(in_char);
    assign is_nul    = (in_char == CH_NUL);
    assign full      = !count_only_reg && (count_reg >= capacity_reg);
    assign count_sat = (count_reg == COUNT_MAX) ? COUNT_MAX : count_reg + 16'd1;

    always_comb begin
        phase_next   = phase_reg;
        nibble_next  = nibble_reg;
        count_next   = count_reg;
        discard_next = discard_reg;
        produce      = 1'b0;
        add          = 1'b0;
        add_val      = in_char;
        fail         = 1'b0;
        result       = '{out_byte: '0, status: ST_DATA, out_count: count_reg, last: 1'b0};

        if (discard_reg) begin
            if (is_nul) begin
                phase_next   = PH_TEXT;
                nibble_next  = '0;
                count_next   = '0;
                discard_next = 1'b0;
            end
        end else if (is_nul) begin
            produce      = 1'b1;
            phase_next   = PH_TEXT;
            nibble_next  = '0;
            count_next   = '0;
            discard_next = 1'b0;
            result.last  = 1'b1;
            if (phase_reg != PH_TEXT || full) begin
                result.status = ST_ERROR;
            end else begin
                result.status    = ST_DONE;
                result.out_count = count_sat;
            end
        end else begin
            unique case (phase_reg)
                PH_TEXT: begin
                    if (in_char == CH_BSLASH) begin
                        phase_next = PH_BSLASH;
                    end else begin
                        add = 1'b1;
                    end
                end
                PH_BSLASH: begin
                    if (in_char == CH_X) begin
                        phase_next = PH_X;
                    end else begin
                        fail = 1'b1;
                    end
                end
                PH_X: begin
                    if (hex.ok) begin
                        nibble_next = hex.val;
                        phase_next  = PH_HIGH;
                    end else begin
                        fail = 1'b1;
                    end
                end
                PH_HIGH: begin
                    if (hex.ok) begin
                        add     = 1'b1;
                        add_val = {nibble_reg, hex.val};
                    end else begin
                        fail = 1'b1;
                    end
                end
                default: fail = 1'b1;
            endcase

            if (add) begin
                phase_next = PH_TEXT;
                if (count_only_reg) begin
                    count_next = count_sat;
                end else if (full) begin
                    fail = 1'b1;
                end else begin
                    count_next       = count_sat;
                    produce          = 1'b1;
                    result.out_byte  = add_val;
                    result.out_count = count_sat;
                end
            end

            if (fail) begin
                produce       = 1'b1;
                phase_next    = PH_TEXT;
                nibble_next   = '0;
                discard_next  = 1'b1;
                result.status = ST_ERROR;
                result.last   = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_TEXT;
            nibble_reg  <= '0;
            count_reg   <= '0;
            discard_reg <= 1'b0;
        end else if (consume) begin
            phase_reg   <= phase_next;
            nibble_reg  <= nibble_next;
            count_reg   <= count_next;
            discard_reg <= discard_next;
        end
    end

endmodule

/* sv/hexd_out_stage.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// hexd_out_stage
// result register toward the master side
// ---------------------------------------------------------------------------
module hexd_out_stage (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              load,
    input  hexd_pkg::result_t result,
    output logic              space,
    output logic              m_tvalid,
    input  logic              m_tready,
    output hexd_pkg::result_t m_result
);
    import hexd_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    result_t res_reg;

    assign space      = !valid_reg || m_tready;
    assign valid_next = load ? 1'b1 : (m_tready ? 1'b0 : valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            res_reg <= result;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_result = res_reg;

endmodule

/* sv/hex_escape_decoder.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// hex_escape_decoder
// backslash-x hex unescape of a NUL-terminated character stream
// ---------------------------------------------------------------------------
// usage
//   s_ channel: one source character per transaction, 0 ends the string
//   m_ channel: at most one result per character: a data byte, the final
//   NUL with the total count, or an error; tlast marks done or error
//   cfg channel: index 0 out_capacity, index 1 count_only; cfg_ready is
//   always high, write only while no string is in flight
//   path: the character sits in the input register, then decode loads the
//   result register, which raises m_tvalid
//   throughput: 1 character per cycle while m_tready keeps the result register free
//   reset: state cleared, out_capacity 65535, count_only 0, both channels
//   empty
//   receiver stall: the result register holds, the input register still
//   takes one more character, then s_tready drops until m_tready returns
// ---------------------------------------------------------------------------
module hex_escape_decoder (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [7:0]                   s_tdata,    // [7:0] in_char
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [23:0]                  m_tdata,    // [7:0] out_byte, [23:8] out_count
    output logic [1:0]                   m_tuser,    // [1:0] status
    output logic                         m_tlast,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [0:0]                   cfg_index,
    input  logic [hexd_pkg::CFG_W-1:0]   cfg_data
);
    import hexd_pkg::*;

    logic              in_valid;
    logic [CHAR_W-1:0] in_char;
    logic              consume;
    logic              produce;
    logic              space;
    result_t           result;
    result_t           m_result;

    assign cfg_ready = 1'b1;
    assign consume   = in_valid && space;

    hexd_in_stage u_in (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .consume  (consume),
        .in_valid (in_valid),
        .in_char  (in_char)
    );

    hexd_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_index (cfg_idx_t'(cfg_index)),
        .cfg_data  (cfg_data),
        .consume   (consume),
        .in_char   (in_char),
        .produce   (produce),
        .result    (result)
    );

    hexd_out_stage u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (consume && produce),
        .result   (result),
        .space    (space),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_result (m_result)
    );

    assign m_tdata = {m_result.out_count, m_result.out_byte};
    assign m_tuser = m_result.status;
    assign m_tlast = m_result.last;

endmodule

/* sv/hexd_checker.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// hexd_checker
// port-level checks of the hex escape decoder
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module hexd_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [7:0]  s_tdata,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata,
    input logic [1:0]  m_tuser,
    input logic        m_tlast,
    input logic        cfg_valid,
    input logic        cfg_ready,
    input logic [0:0]  cfg_index,
    input logic [15:0] cfg_data
);
    import hexd_pkg::*;

    // stalled result stays offered
    `ASSERT_IMPL(a_hold_valid, aclk, aresetn, m_tvalid && !m_tready, ##1 m_tvalid, "m_tvalid dropped while stalled")

    // only data bytes leave tlast low
    `ASSERT_IMPL(a_last_status, aclk, aresetn, m_tvalid, m_tlast == (m_tuser != ST_DATA), "tlast does not match status")

    // done and error carry a zero byte
    `ASSERT_IMPL(a_end_zero, aclk, aresetn, m_tvalid && m_tlast, m_tdata[7:0] == 8'h00, "nonzero byte on final result")

    // a data byte always counts at least itself
    `ASSERT_IMPL(a_data_count, aclk, aresetn, m_tvalid && m_tuser == ST_DATA, m_tdata[23:8] != 16'h0000, "data byte with zero count")

endmodule

bind hex_escape_decoder hexd_checker u_hexd_checker (.*);
